// ----- rtl/dcmps_pkg.sv -----
// Types and constants shared by the DC motor position supervisor.
package dcmps_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_MOVING  = 3'd1,
    MODE_HOMING  = 3'd2,
    MODE_SETTLED = 3'd3,
    MODE_FAULT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_HOME    = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    REG_CAL         = 4'd0,
    REG_STOP_BAND   = 4'd1,
    REG_REARM_BAND  = 4'd2,
    REG_STALL_WIN   = 4'd3,
    REG_HOME_GRACE  = 4'd4,
    REG_HOME_SETTLE = 4'd5,
    REG_ENC_WIDE    = 4'd6,
    REG_POLARITY    = 4'd7
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned IN_DATA_W = 104;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned TGT_W = 18;

  localparam logic [31:0] RUN_TIMEOUT_MS     = 32'd200000;
  localparam logic [31:0] PROGRESS_MIN_COUNT = 32'd10;
  localparam logic [31:0] HOME_MOTION_MAX    = 32'd3;
  localparam logic signed [31:0] NARROW_LIMIT = 32'sd30000;
  localparam logic [31:0] NARROW_SPAN = 32'd65536;

  localparam logic [15:0] CAL_RESET         = 16'd20462;
  localparam logic [15:0] STOP_BAND_RESET   = 16'd20;
  localparam logic [15:0] REARM_BAND_RESET  = 16'd60;
  localparam logic [15:0] STALL_WIN_RESET   = 16'd1500;
  localparam logic [15:0] HOME_GRACE_RESET  = 16'd3000;
  localparam logic [15:0] HOME_SETTLE_RESET = 16'd1200;
  localparam logic [3:0]  ENC_WIDE_RESET    = 4'd9;
  localparam logic [1:0]  POLARITY_RESET    = 2'd3;

endpackage

// ----- rtl/dc_motor_position_supervisor_core.sv -----
// Top level of the DC motor position supervisor: input register, update logic, result register.
// Items move from the input register to the result register when it is free or draining.
// Throughput: one item per cycle unless out_tready stalls; per-motor records sit in flip-flops,
//   read and written in the same cycle, so back-to-back items on the same motor see fresh state.
// Stalls: in_tready drops only while both registers hold items and out_tready is low.
// Reset (synchronous, rst_n low): records zero and idle, registers at defaults, pipeline empty.
module dc_motor_position_supervisor_core #(
  parameter int MOTORS = 4,
  parameter int MAX_MM = 600
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata, low bit up: motor_index[1:0], target_mm[17:2], start_delay_ms[33:18],
  //   now_ms[65:34], encoder_raw[97:66], zero pad [103:98]
  input  logic [dcmps_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]                          in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata, low bit up: motor_out[1:0], mode[4:2], drive_fwd[5], drive_rev[6],
  //   position_pulses[38:7], zero pad [39]
  output logic [dcmps_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dcmps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data
);
  import dcmps_pkg::*;

  localparam int MM_W = $clog2(MAX_MM + 1);
  localparam int PROD_W = MM_W + 16;
  localparam logic [MM_W-1:0] MAX_MM_V = MM_W'(MAX_MM);

  // magnitude of (a - b) taken as a signed 32-bit value
  function automatic logic [31:0] mag_diff(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31] ? (32'd0 - d) : d;
  endfunction

  // ---------------- configuration registers ----------------
  logic [15:0] cal_r, stop_band_r, rearm_band_r, stall_win_r, home_grace_r, home_settle_r;
  logic [3:0]  enc_wide_r;
  logic [1:0]  polarity_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r         <= CAL_RESET;
      stop_band_r   <= STOP_BAND_RESET;
      rearm_band_r  <= REARM_BAND_RESET;
      stall_win_r   <= STALL_WIN_RESET;
      home_grace_r  <= HOME_GRACE_RESET;
      home_settle_r <= HOME_SETTLE_RESET;
      enc_wide_r    <= ENC_WIDE_RESET;
      polarity_r    <= POLARITY_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CAL:         cal_r         <= cfg_data;
        REG_STOP_BAND:   stop_band_r   <= cfg_data;
        REG_REARM_BAND:  rearm_band_r  <= cfg_data;
        REG_STALL_WIN:   stall_win_r   <= cfg_data;
        REG_HOME_GRACE:  home_grace_r  <= cfg_data;
        REG_HOME_SETTLE: home_settle_r <= cfg_data;
        REG_ENC_WIDE:    enc_wide_r    <= cfg_data[3:0];
        REG_POLARITY:    polarity_r    <= cfg_data[1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------- input register ----------------
  logic        in_valid_r;
  cmd_t        in_cmd_r;
  logic [1:0]  in_motor_r;
  logic [15:0] in_mm_r, in_delay_r;
  logic [31:0] in_now_r, in_raw_r;
  logic        out_valid_r;
  logic        advance;

  // the update stage moves whenever the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r   <= cmd_t'(in_tuser);
      in_motor_r <= in_tdata[1:0];
      in_mm_r    <= in_tdata[17:2];
      in_delay_r <= in_tdata[33:18];
      in_now_r   <= in_tdata[65:34];
      in_raw_r   <= in_tdata[97:66];
    end
  end

  // ---------------- per-motor records ----------------
  logic [31:0]      pos_r   [MOTORS];
  logic [31:0]      last_r  [MOTORS];
  logic [TGT_W-1:0] tgt_r   [MOTORS];
  mode_t            mode_r  [MOTORS];
  logic [31:0]      start_r [MOTORS];
  logic [31:0]      refc_r  [MOTORS];
  logic [31:0]      reft_r  [MOTORS];

  // read the record of the addressed motor
  logic             motor_ok;
  logic [31:0]      pos_cur, last_cur, start_cur, refc_cur, reft_cur;
  logic [TGT_W-1:0] tgt_cur;
  mode_t            mode_cur;

  assign motor_ok = int'({1'b0, in_motor_r}) < MOTORS;

  always_comb begin
    pos_cur   = '0;
    last_cur  = '0;
    tgt_cur   = '0;
    mode_cur  = MODE_IDLE;
    start_cur = '0;
    refc_cur  = '0;
    reft_cur  = '0;
    for (int i = 0; i < MOTORS; i++) begin
      if (int'({1'b0, in_motor_r}) == i) begin
        pos_cur   = pos_r[i];
        last_cur  = last_r[i];
        tgt_cur   = tgt_r[i];
        mode_cur  = mode_r[i];
        start_cur = start_r[i];
        refc_cur  = refc_r[i];
        reft_cur  = reft_r[i];
      end
    end
  end

  // ---------------- encoder extension ----------------
  logic        wide;
  logic [31:0] enc_cur, dif_raw, dif_fix, pos_ext, last_ext;

  assign wide    = enc_wide_r[in_motor_r];
  assign enc_cur = wide ? in_raw_r : {{16{in_raw_r[15]}}, in_raw_r[15:0]};
  assign dif_raw = enc_cur - last_cur;

  always_comb begin
    dif_fix = dif_raw;
    if (!wide) begin
      // a 16-bit counter that wrapped: fold the jump back by one counter span
      if ($signed(dif_raw) > NARROW_LIMIT) begin
        dif_fix = dif_raw - NARROW_SPAN;
      end else if ($signed(dif_raw) < -NARROW_LIMIT) begin
        dif_fix = dif_raw + NARROW_SPAN;
      end
    end
  end

  assign pos_ext  = (dif_fix != 32'd0) ? pos_cur + dif_fix : pos_cur;
  assign last_ext = (dif_fix != 32'd0) ? enc_cur : last_cur;

  // ---------------- move scaling ----------------
  logic [MM_W-1:0]   mm_clamp;
  logic [PROD_W-1:0] mm_prod;
  logic [TGT_W-1:0]  tgt_move;
  logic [31:0]       sched_start;

  always_comb begin
    if (in_mm_r[15]) begin
      mm_clamp = '0;
    end else if ({16'd0, in_mm_r} > 32'(MAX_MM)) begin
      mm_clamp = MAX_MM_V;
    end else begin
      mm_clamp = in_mm_r[MM_W-1:0];
    end
  end

  assign mm_prod     = PROD_W'(mm_clamp) * PROD_W'(cal_r);
  assign tgt_move    = TGT_W'(mm_prod >> 8);
  assign sched_start = in_now_r + {16'd0, in_delay_r};

  // ---------------- tick conditions ----------------
  logic [31:0] since, err, err_mag, prog, home_reft;
  logic        pending, mv_settle, run_tmo, mv_prog, stalled, home_moved, home_done;
  logic        fwd_move;

  assign since      = in_now_r - start_cur;
  assign pending    = (mode_cur == MODE_MOVING || mode_cur == MODE_HOMING) && since[31];
  assign err        = {{(32-TGT_W){1'b0}}, tgt_cur} - pos_ext;
  assign err_mag    = err[31] ? (32'd0 - err) : err;
  assign mv_settle  = err_mag <= {16'd0, stop_band_r};
  assign run_tmo    = since > RUN_TIMEOUT_MS;
  assign prog       = mag_diff(pos_ext, refc_cur);
  assign mv_prog    = prog >= PROGRESS_MIN_COUNT;
  assign stalled    = !mv_prog && ((in_now_r - reft_cur) > {16'd0, stall_win_r});
  assign home_moved = prog > HOME_MOTION_MAX;
  // homing holds its reference time at now while in grace or while still moving
  assign home_reft  = (home_moved || since <= {16'd0, home_grace_r}) ? in_now_r : reft_cur;
  assign home_done  = (since > {16'd0, home_grace_r}) &&
                      ((in_now_r - home_reft) > {16'd0, home_settle_r});
  assign fwd_move   = polarity_r[0] ? err[31] : (!err[31] && err != 32'd0);

  // ---------------- next record ----------------
  logic [31:0]      pos_nxt, last_nxt, start_nxt, refc_nxt, reft_nxt;
  logic [TGT_W-1:0] tgt_nxt;
  mode_t            mode_nxt;

  always_comb begin
    pos_nxt   = pos_cur;
    last_nxt  = last_cur;
    tgt_nxt   = tgt_cur;
    mode_nxt  = mode_cur;
    start_nxt = start_cur;
    refc_nxt  = refc_cur;
    reft_nxt  = reft_cur;
    case (in_cmd_r)
      CMD_MOVE: begin
        tgt_nxt   = tgt_move;
        start_nxt = sched_start;
        mode_nxt  = MODE_MOVING;
        refc_nxt  = pos_cur;
        reft_nxt  = sched_start;
      end
      CMD_HOME: begin
        start_nxt = sched_start;
        mode_nxt  = MODE_HOMING;
        refc_nxt  = pos_cur;
        reft_nxt  = sched_start;
      end
      CMD_TICK: begin
        pos_nxt  = pos_ext;
        last_nxt = last_ext;
        if (!pending) begin
          case (mode_cur)
            MODE_MOVING: begin
              if (mv_settle) begin
                mode_nxt = MODE_SETTLED;
              end else if (run_tmo) begin
                mode_nxt = MODE_FAULT;
              end else if (mv_prog) begin
                refc_nxt = pos_ext;
                reft_nxt = in_now_r;
              end else if (stalled) begin
                mode_nxt = MODE_FAULT;
              end
            end
            MODE_HOMING: begin
              reft_nxt = home_reft;
              if (home_moved) begin
                refc_nxt = pos_ext;
              end
              if (home_done) begin
                // end stop reached: zero the count at this tick's encoder value
                pos_nxt  = '0;
                last_nxt = enc_cur;
                tgt_nxt  = '0;
                mode_nxt = MODE_SETTLED;
              end else if (run_tmo) begin
                mode_nxt = MODE_FAULT;
              end
            end
            MODE_SETTLED: begin
              if (err_mag > {16'd0, rearm_band_r}) begin
                mode_nxt  = MODE_MOVING;
                start_nxt = in_now_r;
                refc_nxt  = pos_ext;
                reft_nxt  = in_now_r;
              end
            end
            default: ;  // idle and fault hold
          endcase
        end
      end
      default: ;  // unknown command leaves the record alone
    endcase
  end

  // ---------------- drive pins ----------------
  logic drive_fwd, drive_rev;

  always_comb begin
    drive_fwd = 1'b0;
    drive_rev = 1'b0;
    if (in_cmd_r == CMD_TICK && !pending) begin
      case (mode_cur)
        MODE_MOVING: begin
          if (!mv_settle && !run_tmo && !stalled) begin
            drive_fwd = fwd_move;
            drive_rev = !fwd_move;
          end
        end
        MODE_HOMING: begin
          if (!home_done && !run_tmo) begin
            drive_fwd = polarity_r[1];
            drive_rev = !polarity_r[1];
          end
        end
        default: ;  // no drive in other modes
      endcase
    end
  end

  // ---------------- record write-back ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTORS; i++) begin
        pos_r[i]   <= '0;
        last_r[i]  <= '0;
        tgt_r[i]   <= '0;
        mode_r[i]  <= MODE_IDLE;
        start_r[i] <= '0;
        refc_r[i]  <= '0;
        reft_r[i]  <= '0;
      end
    end else if (advance) begin
      for (int i = 0; i < MOTORS; i++) begin
        if (int'({1'b0, in_motor_r}) == i) begin
          pos_r[i]   <= pos_nxt;
          last_r[i]  <= last_nxt;
          tgt_r[i]   <= tgt_nxt;
          mode_r[i]  <= mode_nxt;
          start_r[i] <= start_nxt;
          refc_r[i]  <= refc_nxt;
          reft_r[i]  <= reft_nxt;
        end
      end
    end
  end

  // ---------------- result register ----------------
  logic [1:0]  out_motor_r;
  mode_t       out_mode_r;
  logic        out_fwd_r, out_rev_r;
  logic [31:0] out_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_motor_r <= in_motor_r;
      // a motor index past the last motor reports an empty record
      out_mode_r  <= motor_ok ? mode_nxt : MODE_IDLE;
      out_fwd_r   <= motor_ok && drive_fwd;
      out_rev_r   <= motor_ok && drive_rev;
      out_pos_r   <= motor_ok ? pos_nxt : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pos_r, out_rev_r, out_fwd_r, out_mode_r, out_motor_r};

  // ---------------- assertions ----------------
  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[5] && out_tdata[6]))
    else $error("both drive pins high");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("pipeline not empty after reset");

  a_schedule_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_cmd_r != CMD_TICK) |=> (!out_tdata[5] && !out_tdata[6]))
    else $error("schedule item drove a pin");

endmodule

// ----- test/dc_motor_position_supervisor_core_tb.sv -----
// Self-checking testbench for the DC motor position supervisor core.
`timescale 1ns / 100ps

module dc_motor_position_supervisor_core_tb;
  import dcmps_pkg::*;

  localparam int MOTORS = 4;
  localparam int MAX_MM = 600;
  // Results pass through the input and result registers; leave some slack after draining.
  localparam int RESULT_SLACK = 6;
  // Run limit in nanoseconds; reaching it ends the run as failed.
  localparam int LIMIT_NS = 8_000_000;
  localparam int PRINT_CAP = 40;

  logic                  clk;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;   // motor_index, target_mm, start_delay_ms, now_ms,
                                     //   encoder_raw, zero pad (low bit up)
  logic [1:0]            in_tuser;   // cmd
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // motor_out, mode, drive_fwd, drive_rev,
                                     //   position_pulses, zero pad (low bit up)
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [15:0]           cfg_data;

  // One result item as the block reports it.
  typedef struct packed {
    logic [1:0]  motor;
    mode_t       mode;
    logic        fwd;
    logic        rev;
    logic [31:0] pos;
  } status_t;

  dc_motor_position_supervisor_core #(
    .MOTORS(MOTORS),
    .MAX_MM(MAX_MM)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the supervisor: registers and per-motor records.
  // ---------------------------------------------------------------------------
  logic [15:0] cal_q8, stop_bnd, rearm_bnd, stall_win, grace_ms, settle_ms;
  logic [3:0]  wide_mask;
  logic [1:0]  pol;

  logic [31:0] pos_cnt    [MOTORS];
  logic [31:0] prev_raw   [MOTORS];
  logic [31:0] tgt_pulses [MOTORS];
  logic [31:0] start_t    [MOTORS];
  logic [31:0] ref_cnt    [MOTORS];
  logic [31:0] ref_t      [MOTORS];
  mode_t       mot_mode   [MOTORS];

  // Status items predicted but not yet seen on the result channel, oldest first.
  status_t status_due[$];

  int items_sent;
  int results_checked;
  int n_errors;
  int mode_seen [5];

  int tx_idle_pct;
  int rx_idle_pct;
  int stall_req;
  int stall_seq;
  int stall_ack;
  int stall_left;
  int longest_stall;

  // Simulated millisecond clock of the motor controller; wraps freely.
  logic [31:0] sim_ms;

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timed out with %0d status items still due", status_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mag_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31] ? -d : d;
  endfunction

  function automatic void clear_model();
    cal_q8    = CAL_RESET;
    stop_bnd  = STOP_BAND_RESET;
    rearm_bnd = REARM_BAND_RESET;
    stall_win = STALL_WIN_RESET;
    grace_ms  = HOME_GRACE_RESET;
    settle_ms = HOME_SETTLE_RESET;
    wide_mask = ENC_WIDE_RESET;
    pol       = POLARITY_RESET;
    for (int i = 0; i < MOTORS; i++) begin
      pos_cnt[i]    = '0;
      prev_raw[i]   = '0;
      tgt_pulses[i] = '0;
      start_t[i]    = '0;
      ref_cnt[i]    = '0;
      ref_t[i]      = '0;
      mot_mode[i]   = MODE_IDLE;
    end
  endfunction

  function automatic void apply_reg(logic [3:0] idx, logic [15:0] val);
    case (idx)
      REG_CAL:         cal_q8    = val;
      REG_STOP_BAND:   stop_bnd  = val;
      REG_REARM_BAND:  rearm_bnd = val;
      REG_STALL_WIN:   stall_win = val;
      REG_HOME_GRACE:  grace_ms  = val;
      REG_HOME_SETTLE: settle_ms = val;
      REG_ENC_WIDE:    wide_mask = val[3:0];
      REG_POLARITY:    pol       = val[1:0];
      default: ;  // unused index: no register behind it
    endcase
  endfunction

  // Advance the shadow record of one motor by one item and return its status.
  function automatic status_t supervise_item(cmd_t cmd, logic [1:0] m, logic [15:0] mm_bits,
                                             logic [15:0] dly, logic [31:0] now,
                                             logic [31:0] raw);
    status_t     r;
    int          mm;
    int          d;
    logic [31:0] prod, cur, dif, err, since;
    logic        wide, f, stalled;
    mode_t       md;
    r.motor = m;
    r.fwd   = 1'b0;
    r.rev   = 1'b0;
    wide    = wide_mask[m];
    case (cmd)
      CMD_MOVE: begin
        mm = $signed(mm_bits);
        if (mm < 0) mm = 0;
        if (mm > MAX_MM) mm = MAX_MM;
        prod = 32'(mm) * 32'(cal_q8);
        tgt_pulses[m] = {14'd0, prod[TGT_W+7:8]};
        start_t[m]    = now + 32'(dly);
        mot_mode[m]   = MODE_MOVING;
        ref_cnt[m]    = pos_cnt[m];
        ref_t[m]      = start_t[m];
      end
      CMD_HOME: begin
        start_t[m]  = now + 32'(dly);
        mot_mode[m] = MODE_HOMING;
        ref_cnt[m]  = pos_cnt[m];
        ref_t[m]    = start_t[m];
      end
      CMD_TICK: begin
        // Extend the raw counter into the running count.
        cur = wide ? raw : {{16{raw[15]}}, raw[15:0]};
        dif = cur - prev_raw[m];
        md  = mot_mode[m];
        if (!wide) begin
          d = $signed(dif);
          if (d > NARROW_LIMIT) d = d - int'(NARROW_SPAN);
          else if (d < -NARROW_LIMIT) d = d + int'(NARROW_SPAN);
          dif = d;
        end
        if (dif != 0) begin
          pos_cnt[m]  = pos_cnt[m] + dif;
          prev_raw[m] = cur;
        end
        since = now - start_t[m];
        if ((md == MODE_MOVING || md == MODE_HOMING) && since[31]) begin
          // start still ahead: keep the drive off
        end else if (md == MODE_MOVING) begin
          err = tgt_pulses[m] - pos_cnt[m];
          if (mag_of(tgt_pulses[m], pos_cnt[m]) <= 32'(stop_bnd)) begin
            mot_mode[m] = MODE_SETTLED;
          end else if (since > RUN_TIMEOUT_MS) begin
            mot_mode[m] = MODE_FAULT;
          end else begin
            stalled = 1'b0;
            if (mag_of(pos_cnt[m], ref_cnt[m]) >= PROGRESS_MIN_COUNT) begin
              ref_cnt[m] = pos_cnt[m];
              ref_t[m]   = now;
            end else if ((now - ref_t[m]) > 32'(stall_win)) begin
              mot_mode[m] = MODE_FAULT;
              stalled     = 1'b1;
            end
            if (!stalled) begin
              f     = pol[0] ? err[31] : (!err[31] && err != 0);
              r.fwd = f;
              r.rev = !f;
            end
          end
        end else if (md == MODE_HOMING) begin
          if (mag_of(pos_cnt[m], ref_cnt[m]) > HOME_MOTION_MAX) begin
            ref_cnt[m] = pos_cnt[m];
            ref_t[m]   = now;
          end else if (since <= 32'(grace_ms)) begin
            ref_t[m] = now;
          end
          if (since > 32'(grace_ms) && (now - ref_t[m]) > 32'(settle_ms)) begin
            pos_cnt[m]    = '0;
            prev_raw[m]   = cur;
            tgt_pulses[m] = '0;
            mot_mode[m]   = MODE_SETTLED;
          end else if (since > RUN_TIMEOUT_MS) begin
            mot_mode[m] = MODE_FAULT;
          end else begin
            r.fwd = pol[1];
            r.rev = !pol[1];
          end
        end else if (md == MODE_SETTLED) begin
          if (mag_of(tgt_pulses[m], pos_cnt[m]) > 32'(rearm_bnd)) begin
            mot_mode[m] = MODE_MOVING;
            start_t[m]  = now;
            ref_cnt[m]  = pos_cnt[m];
            ref_t[m]    = now;
          end
        end
      end
      default: ;  // unknown command: report the motor untouched
    endcase
    r.mode = mot_mode[m];
    r.pos  = pos_cnt[m];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready with an optional long hold-off, and the checker.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_seq != stall_ack) begin
      stall_left = stall_req;
      stall_ack  = stall_seq;
    end
    if (stall_left != 0) begin
      // hold off the result channel until the countdown runs out
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("%0t: %s wrong at result %0d: got 0x%08h, want 0x%08h",
               $realtime, what, results_checked, got, want);
  endtask

  always @(posedge clk) begin : check_results
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with nothing due", out_tdata[31:0], '0);
      end else begin
        want = status_due.pop_front();
        if (out_tdata[1:0] !== want.motor)
          report_mismatch("motor_out", 32'(out_tdata[1:0]), 32'(want.motor));
        if (out_tdata[4:2] !== want.mode)
          report_mismatch("mode", 32'(out_tdata[4:2]), 32'(want.mode));
        if (out_tdata[5] !== want.fwd)
          report_mismatch("drive_fwd", 32'(out_tdata[5]), 32'(want.fwd));
        if (out_tdata[6] !== want.rev)
          report_mismatch("drive_rev", 32'(out_tdata[6]), 32'(want.rev));
        if (out_tdata[38:7] !== want.pos)
          report_mismatch("position_pulses", out_tdata[38:7], want.pos);
        if (want.mode <= MODE_FAULT) mode_seen[want.mode]++;
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one item, hold it until taken, then predict its status.
  task automatic send_item(cmd_t cmd, logic [1:0] m, logic [15:0] mm, logic [15:0] dly,
                           logic [31:0] now, logic [31:0] raw);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {6'd0, raw, now, dly, mm, m};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    status_due.push_back(supervise_item(cmd, m, mm, dly, now, raw));
    items_sent++;
  endtask

  // Tick one motor: advance the clock and move its encoder by step counts.
  task automatic tick_motor(logic [1:0] m, int step, logic [31:0] adv);
    logic [31:0] raw;
    sim_ms += adv;
    raw = prev_raw[m] + step;
    if (!wide_mask[m]) raw[31:16] = 16'($urandom);  // upper half ignored on narrow counters
    send_item(CMD_TICK, m, 16'($urandom), 16'($urandom), sim_ms, raw);
  endtask

  // Drop valid and wait until every predicted status item has come back.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (RESULT_SLACK) @(posedge clk);
  endtask

  task automatic set_reg(logic [3:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  // Write every register, then one unused index; junk goes in the unused upper bits of the narrow ones.
  task automatic load_config(logic [15:0] cal, logic [15:0] sb, logic [15:0] rb,
                             logic [15:0] sw, logic [15:0] hg, logic [15:0] hs,
                             logic [3:0] mask, logic [1:0] p);
    set_reg(REG_CAL, cal);
    set_reg(REG_STOP_BAND, sb);
    set_reg(REG_REARM_BAND, rb);
    set_reg(REG_STALL_WIN, sw);
    set_reg(REG_HOME_GRACE, hg);
    set_reg(REG_HOME_SETTLE, hs);
    set_reg(REG_ENC_WIDE, {12'($urandom), mask});
    set_reg(REG_POLARITY, {14'($urandom), p});
    set_reg(4'($urandom_range(8, 15)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Clock advance between ticks: mostly short, sometimes past stall or run timeouts.
  function automatic logic [31:0] next_advance();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 0;
    if (pick < 70) return $urandom_range(1, 100);
    if (pick < 88) return $urandom_range(100, 2000);
    if (pick < 97) return $urandom_range(2000, 20000);
    return $urandom_range(190000, 260000);
  endfunction

  // One short, mostly well-formed sequence on a random motor.
  task automatic run_scenario();
    logic [1:0]  m;
    logic [15:0] mm, dly;
    int          kind, pick, n, e, lim, step, span, sgn;
    m    = 2'($urandom);
    kind = $urandom_range(0, 99);
    sgn  = $urandom_range(0, 1) ? 1 : -1;
    if (kind < 45) begin
      // move: schedule, then ticks that mostly chase the target
      pick = $urandom_range(0, 99);
      mm   = (pick < 70) ? 16'($urandom_range(0, 30)) :
             (pick < 90) ? 16'($urandom_range(0, MAX_MM)) : 16'($urandom);
      pick = $urandom_range(0, 99);
      dly  = (pick < 60) ? 16'($urandom_range(0, 50)) :
             (pick < 90) ? 16'($urandom_range(50, 1000)) : 16'($urandom);
      send_item(CMD_MOVE, m, mm, dly, sim_ms, $urandom);
      n = $urandom_range(4, 30);
      repeat (n) begin
        e    = $signed(tgt_pulses[m] - pos_cnt[m]);
        lim  = $urandom_range(1, 3000);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          step = (e > lim) ? lim : (e < -lim) ? -lim : e;
          if ($urandom_range(0, 9) == 0) step += $urandom_range(0, 160) - 80;
        end else if (pick < 85) begin
          step = $urandom_range(0, 6) - 3;
        end else begin
          step = $urandom_range(0, 10000) - 5000;
        end
        tick_motor(m, step, next_advance());
      end
    end else if (kind < 70) begin
      // homing: some travel, then a quiet end stop, sometimes a disturbance after
      send_item(CMD_HOME, m, 16'($urandom), 16'($urandom_range(0, 40)), sim_ms, $urandom);
      span = (int'(grace_ms) + int'(settle_ms)) / 4 + 20;
      n = $urandom_range(0, 5);
      repeat (n) tick_motor(m, sgn * int'($urandom_range(4, 500)), $urandom_range(1, span));
      n = $urandom_range(3, 15);
      repeat (n) tick_motor(m, $urandom_range(0, 6) - 3, $urandom_range(1, span));
      if ($urandom_range(0, 9) < 3)
        tick_motor(m, sgn * (int'(rearm_bnd) + int'($urandom_range(1, 500))), 1);
    end else if (kind < 85) begin
      // drift around the re-arm band of whatever state the motor is in
      lim = int'(rearm_bnd) * 2 + 10;
      if (lim > 20000) lim = 20000;
      n = $urandom_range(1, 4);
      repeat (n) tick_motor(m, $urandom_range(0, 2 * lim) - lim, next_advance());
    end else begin
      // noise: any command, any fields
      n = $urandom_range(1, 3);
      repeat (n)
        send_item(cmd_t'($urandom_range(0, 3)), 2'($urandom), 16'($urandom), 16'($urandom),
                  $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests (default registers: motors 0 and 3 wide, 1 and 2 narrow)
  // ---------------------------------------------------------------------------
  task automatic test_idle_ticks();
    for (int i = 0; i < MOTORS; i++)
      send_item(CMD_TICK, 2'(i), 16'h0000, 16'h0000, sim_ms, 32'h0);
    // wide counter stepping back across zero
    send_item(CMD_TICK, 2'd0, 16'hFFFF, 16'hFFFF, sim_ms, 32'hFFFF_FFFF);
  endtask

  task automatic test_move_clamp();
    send_item(CMD_MOVE, 2'd0, 16'h8000, 16'h0000, sim_ms, 32'h0);          // most negative
    send_item(CMD_MOVE, 2'd3, 16'h7FFF, 16'h0001, sim_ms, 32'hFFFF_FFFF);  // above max
    send_item(CMD_MOVE, 2'd1, 16'(MAX_MM), 16'hFFFF, sim_ms, 32'h0);       // longest delay
    send_item(CMD_MOVE, 2'd2, 16'h0000, 16'h0000, sim_ms, 32'h0);
    sim_ms += 1;
    // motor 0 sits one count off a zero target: inside the stop band
    send_item(CMD_TICK, 2'd0, 16'h0, 16'h0, sim_ms, 32'hFFFF_FFFF);
  endtask

  task automatic test_encoder_extension();
    sim_ms += 1;
    // narrow jump above the fold limit, then back below it
    send_item(CMD_TICK, 2'd1, 16'h0, 16'h0, sim_ms, 32'hABCD_7600);
    send_item(CMD_TICK, 2'd1, 16'h0, 16'h0, sim_ms, 32'h1234_0000);
  endtask

  task automatic test_start_delay_and_timeout();
    sim_ms += 10;
    send_item(CMD_TICK, 2'd1, 16'h0, 16'h0, sim_ms, 32'h0);  // start still ahead
    sim_ms += 65524 + int'(RUN_TIMEOUT_MS) + 1;               // two past the run timeout
    send_item(CMD_TICK, 2'd1, 16'h0, 16'h0, sim_ms, 32'h0);
  endtask

  task automatic test_unknown_command();
    send_item(CMD_UNKNOWN, 2'd3, 16'($urandom), 16'($urandom), sim_ms, $urandom);
  endtask

  task automatic test_homing();
    sim_ms += 1;
    send_item(CMD_HOME, 2'd2, 16'h0, 16'h0, sim_ms, 32'h0);
    sim_ms += 100;
    send_item(CMD_TICK, 2'd2, 16'h0, 16'h0, sim_ms, 32'd500);   // travel inside grace
    sim_ms += 4900;
    send_item(CMD_TICK, 2'd2, 16'h0, 16'h0, sim_ms, 32'd500);   // quiet past grace: settle
    sim_ms += 1;
    send_item(CMD_TICK, 2'd2, 16'h0, 16'h0, sim_ms, 32'd600);   // pushed out: re-arm
    sim_ms += 1;
    send_item(CMD_TICK, 2'd2, 16'h0, 16'h0, sim_ms, 32'd600);   // drives back
  endtask

  // ---------------------------------------------------------------------------
  // Flow-control tests
  // ---------------------------------------------------------------------------
  task automatic test_output_stall();
    int first;
    tx_idle_pct   = 0;
    longest_stall = 300;
    stall_req     = longest_stall;
    stall_seq++;
    first         = items_sent;
    // keep offering while results are held back; the input must back up
    while (items_sent - first < 40) run_scenario();
  endtask

  task automatic test_sender_pause();
    run_scenario();
    wait_drain();
    run_scenario();
  endtask

  task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
    int first;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    first       = items_sent;
    while (items_sent - first < n_items) run_scenario();
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_TICK;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_CAL;
    cfg_data    <= '0;
    tx_idle_pct = 16;
    rx_idle_pct = 46;
    stall_req   = 0;
    clear_model();
    sim_ms = 32'hFFFF_FF00;  // start just below the wrap of the millisecond clock

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_move_clamp();
    test_encoder_extension();
    test_start_delay_and_timeout();
    test_unknown_command();
    test_homing();
    test_output_stall();
    test_sender_pause();
    wait_drain();

    // moderate settings, sender idles lightly, receiver heavily
    load_config(16'($urandom_range(4000, 30000)), 16'($urandom_range(0, 30)),
                16'($urandom_range(30, 200)), 16'($urandom_range(100, 800)),
                16'($urandom_range(50, 400)), 16'($urandom_range(30, 300)),
                4'($urandom), 2'($urandom));
    test_random_traffic(450, 16, 46);
    // every register at its top, idling swapped
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 2'd3);
    test_random_traffic(450, 46, 16);
    // every register at zero, no idling
    load_config(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 4'h0, 2'd0);
    test_random_traffic(450, 0, 0);
    // back to moderate, no idling
    load_config(16'($urandom_range(4000, 30000)), 16'($urandom_range(0, 30)),
                16'($urandom_range(30, 200)), 16'($urandom_range(100, 800)),
                16'($urandom_range(50, 400)), 16'($urandom_range(30, 300)),
                4'($urandom), 2'($urandom));
    test_random_traffic(450, 0, 0);

    $display("Covered %0d items and %0d results over four register settings and the defaults,",
             items_sent, results_checked);
    $display("with a %0d-cycle result stall; statuses idle %0d moving %0d homing %0d settled %0d fault %0d",
             longest_stall, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dcmps_pkg.sv
rtl/dc_motor_position_supervisor_core.sv
test/dc_motor_position_supervisor_core_tb.sv
